FILE: rtl/sbrs_pkg.sv
// shared types, constants and crc helpers for the sideband reply segmenter
package sbrs_pkg;

  parameter int MSG_BYTES_DEF = 256;

  localparam int ROUTE_PER_SLOT = 7;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int CFG_W   = 7;

  localparam logic [CFG_W-1:0] SEG_LIMIT_MIN   = 7'd12;
  localparam logic [CFG_W-1:0] SEG_LIMIT_MAX   = 7'd64;
  localparam logic [CFG_W-1:0] SEG_LIMIT_RESET = 7'd48;

  localparam logic [4:0] CRC4_POLY = 5'h13;
  localparam logic [8:0] CRC8_POLY = 9'h1d5;

  // register index of max_segment_bytes (word address)
  localparam logic [PADDR_W-3:0] REG_MAX_SEG = '0;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_ROUTE  = 2'd1,
    OP_EMIT   = 2'd2
  } sbrs_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_SETUP,
    ST_HDR,
    ST_DATA,
    ST_CRC
  } sbrs_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       segment_valid;
    logic       pending;
    logic       rejected;
  } sbrs_res_t;

  // header crc4, one byte msb first
  function automatic logic [3:0] crc4_byte(input logic [3:0] rem, input logic [7:0] d);
    logic [4:0] t;
    t = {1'b0, rem};
    for (int i = 7; i >= 0; i--) begin
      t = {t[3:0], d[i]};
      if (t[4]) begin
        t = t ^ CRC4_POLY;
      end
    end
    return t[3:0];
  endfunction

  // body crc8, one byte msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] rem, input logic [7:0] d);
    logic [8:0] t;
    t = {1'b0, rem};
    for (int i = 7; i >= 0; i--) begin
      t = {t[7:0], d[i]};
      if (t[8]) begin
        t = t ^ CRC8_POLY;
      end
    end
    return t[7:0];
  endfunction

endpackage

FILE: rtl/sbrs_ram.sv
// generic simple dual port ram with registered read
module sbrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sbrs_cfg.sv
// apb register for the segment size limit
module sbrs_cfg import sbrs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CFG_W-1:0]   seg_limit
);

  logic [CFG_W-1:0] max_seg;
  logic             hit;

  assign hit    = (paddr[PADDR_W-1:2] == REG_MAX_SEG);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_seg <= SEG_LIMIT_RESET;
    end else if (psel && penable && pwrite && hit) begin
      max_seg <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = hit ? {{(PDATA_W-CFG_W){1'b0}}, max_seg} : '0;

  // clamp into the legal segment range
  always_comb begin
    if (max_seg < SEG_LIMIT_MIN) begin
      seg_limit = SEG_LIMIT_MIN;
    end else if (max_seg > SEG_LIMIT_MAX) begin
      seg_limit = SEG_LIMIT_MAX;
    end else begin
      seg_limit = max_seg;
    end
  end

endmodule

FILE: rtl/sbrs_obuf.sv
// output register stage for result transfers
module sbrs_obuf import sbrs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  sbrs_res_t res,
  input  logic      out_stall,
  output logic      free,
  output logic      out_valid,
  output sbrs_res_t res_q
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

FILE: rtl/sbrs_seq.sv
// slot state and segment sequencer around the reply store
module sbrs_seq import sbrs_pkg::*; #(
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     operation,
  input  logic                           slot,
  input  logic [7:0]                     data_byte,
  input  logic [3:0]                     link_count,
  input  logic [2:0]                     route_index,
  input  logic [CFG_W-1:0]               seg_limit,
  input  logic                           free,
  output logic                           load,
  output sbrs_res_t                      res,
  output logic                           ram_we,
  output logic [$clog2(2*MSG_BYTES)-1:0] ram_waddr,
  output logic [7:0]                     ram_wdata,
  output logic [$clog2(2*MSG_BYTES)-1:0] ram_raddr,
  input  logic [7:0]                     ram_rdata
);

  localparam int LEN_W = $clog2(MSG_BYTES + 1);
  localparam int OFF_W = $clog2(MSG_BYTES);
  localparam int AW    = $clog2(2 * MSG_BYTES);

  sbrs_state_t state, state_next;

  logic [LEN_W-1:0] len [2];
  logic [LEN_W-1:0] pos [2];
  logic [3:0]       lcnt [2];
  logic [7:0]       route [2][ROUTE_PER_SLOT];
  logic             cur_slot;

  // latched segment description
  logic             seg_sel;
  logic [LEN_W-1:0] seg_pos;
  logic [LEN_W-1:0] seg_len;
  logic [3:0]       seg_lc;
  logic [CFG_W-1:0] seg_limit_q;
  logic [6:0]       seg_body;
  logic [5:0]       seg_dlen;
  logic             seg_start;
  logic             seg_end;
  logic             seg_pend;
  logic             seg_rej;
  logic [3:0]       hidx;
  logic [5:0]       dcnt;
  logic [3:0]       crc4;
  logic [7:0]       crc8;

  logic             accept;
  sbrs_op_t         op;
  logic             pick;
  logic             pick_empty;
  logic             has_room;
  logic             any_pend;
  logic [2:0]       seg_rad;
  logic [3:0]       hdr_len;
  logic [6:0]       room;
  logic [LEN_W-1:0] remain;
  logic             fits;
  logic [6:0]       body_c;
  logic [5:0]       dlen_c;
  logic [7:0]       hdr_byte;
  logic [3:0]       flags_hi;
  logic [3:0]       crc4_fin;
  logic [2:0]       ri;
  logic [5:0]       dcnt_next;
  logic [LEN_W:0]   off_sum;
  logic [OFF_W-1:0] off;

  assign op         = sbrs_op_t'(operation);
  assign accept     = in_valid && (state == ST_IDLE);
  assign in_stall   = (state != ST_IDLE);
  assign pick       = (len[cur_slot] == '0) ? ~cur_slot : cur_slot;
  assign pick_empty = (len[pick] == '0);
  assign has_room   = (len[slot] < LEN_W'(MSG_BYTES));
  assign any_pend   = (len[0] != '0) || (len[1] != '0);

  // segment sizing
  assign seg_rad = seg_lc[3:1];
  assign hdr_len = {1'b0, seg_rad} + 4'd3;
  assign room    = seg_limit_q - {3'b0, hdr_len};
  assign remain  = seg_len - seg_pos;
  assign fits    = (remain < LEN_W'(room));
  assign body_c  = fits ? (remain[6:0] + 7'd1) : room;
  assign dlen_c  = 6'(body_c - 7'd1);

  // header bytes
  assign flags_hi = {seg_start, seg_end, 1'b0, seg_sel};
  assign crc4_fin = crc4_byte(crc4, {flags_hi, 4'h0});
  assign ri       = 3'(hidx - 4'd1);

  always_comb begin
    if (hidx == 4'd0) begin
      hdr_byte = {seg_lc, seg_lc - 4'd1};
    end else if (hidx <= {1'b0, seg_rad}) begin
      hdr_byte = route[seg_sel][ri];
    end else if (hidx == {1'b0, seg_rad} + 4'd1) begin
      hdr_byte = {1'b0, seg_body};
    end else begin
      hdr_byte = {flags_hi, crc4_fin};
    end
  end

  // store read follows the next data index so the byte is ready when needed
  assign dcnt_next = dcnt + 6'((state == ST_DATA) && load);
  assign off_sum   = {1'b0, seg_pos} + (LEN_W+1)'(dcnt_next);
  assign off       = (off_sum >= (LEN_W+1)'(MSG_BYTES)) ?
                     OFF_W'(off_sum - (LEN_W+1)'(MSG_BYTES)) : OFF_W'(off_sum);
  assign ram_raddr = seg_sel ? (AW'(MSG_BYTES) + AW'(off)) : AW'(off);

  assign ram_we    = accept && (op == OP_APPEND) && has_room;
  assign ram_waddr = slot ? (AW'(MSG_BYTES) + AW'(len[slot])) : AW'(len[slot]);
  assign ram_wdata = data_byte;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (op == OP_EMIT && !pick_empty) begin
            state_next = ST_SETUP;
          end else begin
            state_next = ST_ACK;
          end
        end
      end
      ST_ACK: begin
        if (free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SETUP: state_next = ST_HDR;
      ST_HDR: begin
        if (free && hidx == {1'b0, seg_rad} + 4'd2) begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        if (free && dcnt == seg_dlen - 6'd1) begin
          state_next = ST_CRC;
        end
      end
      ST_CRC: begin
        if (free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result generation
  always_comb begin
    res  = '0;
    load = 1'b0;
    unique case (state)
      ST_ACK: begin
        res.last     = 1'b1;
        res.pending  = any_pend;
        res.rejected = seg_rej;
        load         = free;
      end
      ST_HDR: begin
        res.out_byte      = hdr_byte;
        res.segment_valid = 1'b1;
        res.pending       = seg_pend;
        load              = free;
      end
      ST_DATA: begin
        res.out_byte      = ram_rdata;
        res.segment_valid = 1'b1;
        res.pending       = seg_pend;
        load              = free;
      end
      ST_CRC: begin
        res.out_byte      = crc8_byte(crc8, 8'h00);
        res.last          = 1'b1;
        res.segment_valid = 1'b1;
        res.pending       = seg_pend;
        load              = free;
      end
      ST_IDLE, ST_SETUP: begin
        res  = '0;
        load = 1'b0;
      end
      default: begin
        res  = '0;
        load = 1'b0;
      end
    endcase
  end

  // slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur_slot <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        len[s]  <= '0;
        pos[s]  <= '0;
        lcnt[s] <= '0;
        for (int r = 0; r < ROUTE_PER_SLOT; r++) begin
          route[s][r] <= '0;
        end
      end
    end else begin
      state <= state_next;
      if (accept) begin
        unique case (op)
          OP_APPEND: begin
            if (has_room) begin
              len[slot] <= len[slot] + LEN_W'(1);
            end
          end
          OP_ROUTE: begin
            lcnt[slot] <= link_count;
            if (route_index < 3'(ROUTE_PER_SLOT)) begin
              route[slot][route_index] <= data_byte;
            end
          end
          OP_EMIT: cur_slot <= pick;
          default: ;
        endcase
      end
      if (state == ST_SETUP) begin
        if (!fits) begin
          pos[seg_sel] <= seg_pos + LEN_W'(dlen_c);
        end else begin
          len[seg_sel] <= '0;
          pos[seg_sel] <= '0;
          cur_slot     <= ~seg_sel;
        end
      end
    end
  end

  // segment working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      seg_rej     <= (op == OP_APPEND) && !has_room;
      seg_sel     <= pick;
      seg_pos     <= pos[pick];
      seg_len     <= len[pick];
      seg_lc      <= lcnt[pick];
      seg_limit_q <= seg_limit;
    end
    if (state == ST_SETUP) begin
      seg_body  <= body_c;
      seg_dlen  <= dlen_c;
      seg_start <= (seg_pos == '0);
      seg_end   <= fits;
      seg_pend  <= (len[~seg_sel] != '0) || !fits;
      hidx      <= '0;
      dcnt      <= '0;
      crc4      <= '0;
      crc8      <= '0;
    end
    if (state == ST_HDR && load) begin
      crc4 <= crc4_byte(crc4, hdr_byte);
      hidx <= hidx + 4'd1;
    end
    if (state == ST_DATA && load) begin
      crc8 <= crc8_byte(crc8, ram_rdata);
      dcnt <= dcnt_next;
    end
  end

endmodule

FILE: rtl/sideband_reply_segmenter.sv
// top level of the sideband reply segmenter
//
// input channel (in_valid / in_stall) carries one command per transfer:
// append a reply byte to a slot, set a routing byte and link count, or emit
// the next segment of the current reply slot
// output channel (out_valid / out_stall) carries result transfers; append,
// routing and empty emit commands answer with one acknowledgement, an emit
// answers with the whole segment: link count byte, routing bytes, body
// length, flags with header crc4, body bytes and body crc8, last on the end
// an acknowledgement is built in the ack state after its command is taken
// and is registered in the output register; an emit passes a setup state,
// then gives one segment byte per cycle while the output is not stalled,
// the reply store then delivering one body byte a cycle
// one command is worked on at a time; in_stall is high until its results
// are all loaded into the output register
// a stalled result holds in the output register and the sequencer waits
// reset clears slot lengths, positions, link counts, routing bytes and the
// current slot, and restores the segment limit to 48; the reply store itself
// is not cleared, it is only read below a slot's fill length
// the segment limit lives behind an apb port at byte address 0
module sideband_reply_segmenter import sbrs_pkg::*; #(
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic               slot,
  input  logic [7:0]         data_byte,
  input  logic [3:0]         link_count,
  input  logic [2:0]         route_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               last,
  output logic               segment_valid,
  output logic               pending,
  output logic               rejected,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW = $clog2(2 * MSG_BYTES);

  logic [CFG_W-1:0] seg_limit;
  logic             free;
  logic             load;
  sbrs_res_t        res;
  sbrs_res_t        res_q;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  // segment limit register
  sbrs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .seg_limit (seg_limit)
  );

  // reply store, both slots side by side
  sbrs_ram #(
    .WIDTH (8),
    .DEPTH (2 * MSG_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // slot bookkeeping and segment framing
  sbrs_seq #(
    .MSG_BYTES (MSG_BYTES)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .slot        (slot),
    .data_byte   (data_byte),
    .link_count  (link_count),
    .route_index (route_index),
    .seg_limit   (seg_limit),
    .free        (free),
    .load        (load),
    .res         (res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  // result register, holds a transfer while the receiver stalls
  sbrs_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .res       (res),
    .out_stall (out_stall),
    .free      (free),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign out_byte      = res_q.out_byte;
  assign last          = res_q.last;
  assign segment_valid = res_q.segment_valid;
  assign pending       = res_q.pending;
  assign rejected      = res_q.rejected;

endmodule

FILE: rtl/sbrs_chk.sv
// port level checker for the sideband reply segmenter, with its bind
module sbrs_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last,
  input logic       segment_valid,
  input logic       rejected
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("stalled result changed");

  // acknowledgements are single zero results
  a_ack_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !segment_valid |-> last && out_byte == 8'd0)
    else $error("malformed acknowledgement");

  // a rejected append never carries segment data
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> !segment_valid)
    else $error("rejection on a segment byte");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("command taken while busy");

endmodule

bind sideband_reply_segmenter sbrs_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .last          (last),
  .segment_valid (segment_valid),
  .rejected      (rejected)
);
